### sv/assert_macros.svh
// Assertion macros for the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising clock edge outside reset.
`define KCH_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks that cons holds in the cycle in which ante holds.
`define KCH_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

### sv/kch_pkg.sv
// Types and constants of the cluster head selection block.
`timescale 1ns / 1ps

package kch_pkg;

   localparam int COORD_W = 16;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int DIST_W  = 2 * DIFF_W;
   localparam int ROOT_W  = DIST_W / 2;
   localparam int COST_W  = 24;

   localparam logic [1:0] CSR_HEAD_COUNT = 2'd0;
   localparam logic [1:0] CSR_PASS_LIMIT = 2'd1;

   localparam logic [3:0] HEAD_COUNT_RESET = 4'd4;
   localparam logic [7:0] PASS_LIMIT_RESET = 8'd255;

   typedef struct packed {
      logic signed [COORD_W-1:0] x_coord;
      logic signed [COORD_W-1:0] y_coord;
      logic                      last_node;
   } req_type;

   typedef struct packed {
      logic [5:0] node_index;
      logic [2:0] cluster_index;
      logic [5:0] head_node;
      logic       is_head;
      logic       failed;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] a_x;
      logic [COORD_W-1:0] a_y;
      logic [COORD_W-1:0] b_x;
      logic [COORD_W-1:0] b_y;
   } pair_type;

   typedef enum logic [4:0] {
      S_LOAD,
      S_START,
      S_SEED_RD,
      S_SEED_WR,
      S_ASG_RD,
      S_ASG_DIST,
      S_ASG_WAIT,
      S_ASG_WR,
      S_UPD_INIT,
      S_UPD_RD_I,
      S_UPD_CHK_I,
      S_UPD_RD_J,
      S_UPD_CHK_J,
      S_UPD_WAIT,
      S_UPD_SQRT,
      S_UPD_NEXT_J,
      S_UPD_NEXT_I,
      S_PASS_END,
      S_DUP,
      S_OUT_RD,
      S_OUT,
      S_FAIL
   } state_type;

endpackage

### sv/kch_dist.sv
// Three-stage squared Euclidean distance between two points.
`timescale 1ns / 1ps

module kch_dist (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  kch_pkg::pair_type             pair,
   output logic                          done,
   output logic [kch_pkg::DIST_W-1:0]    sq_dist
);

   logic                                v1_ff, v2_ff, v3_ff;
   logic signed [kch_pkg::DIFF_W-1:0]   dx_ff, dy_ff;
   logic signed [kch_pkg::DIST_W-1:0]   sqx_ff, sqy_ff;
   logic [kch_pkg::DIST_W-1:0]          sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff  <= $signed({pair.a_x[kch_pkg::COORD_W-1], pair.a_x})
              - $signed({pair.b_x[kch_pkg::COORD_W-1], pair.b_x});
      dy_ff  <= $signed({pair.a_y[kch_pkg::COORD_W-1], pair.a_y})
              - $signed({pair.b_y[kch_pkg::COORD_W-1], pair.b_y});
      sqx_ff <= dx_ff * dx_ff;
      sqy_ff <= dy_ff * dy_ff;
      sum_ff <= $unsigned(sqx_ff) + $unsigned(sqy_ff);
   end

   assign done    = v3_ff;
   assign sq_dist = sum_ff;

endmodule

### sv/kch_isqrt.sv
// Iterative floor square root, one result bit per cycle.
`timescale 1ns / 1ps

module kch_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [kch_pkg::DIST_W-1:0]    value,
   output logic                          done,
   output logic [kch_pkg::ROOT_W-1:0]    root
);

   localparam logic [kch_pkg::DIST_W-1:0] BIT_INIT =
      {2'b01, {(kch_pkg::DIST_W-2){1'b0}}};

   logic                          busy_ff, busy_in;
   logic [kch_pkg::DIST_W-1:0]    rem_ff, rem_in;
   logic [kch_pkg::DIST_W-1:0]    res_ff, res_in;
   logic [kch_pkg::DIST_W-1:0]    bit_ff, bit_in;
   logic [kch_pkg::DIST_W-1:0]    trial;

   always_comb begin
      trial   = res_ff + bit_ff;
      busy_in = busy_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = value;
         res_in  = '0;
         bit_in  = BIT_INIT;
      end else if (busy_ff) begin
         if (bit_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = busy_ff && (bit_ff == '0);
   assign root = res_ff[kch_pkg::ROOT_W-1:0];

endmodule

### sv/kmedoid_cluster_heads_core.sv
// Top level of the k-medoids cluster head selection block.
//
// Nodes arrive on the req channel, one transfer per cycle, and are written
// into the node memory; a transfer with last_node set starts clustering.
// Nodes beyond MAX_NODES are dropped. The req channel stalls for the whole
// clustering run and the output phase, and is open again after the final
// result has been loaded into the output register.
// The run is sequenced over the node and membership memories, one read a
// cycle. An assignment step runs the distance pipeline for each node and head;
// the update step runs each member pair through the distance pipeline, then the
// square root. Passes repeat until the heads settle, up to pass_limit per
// attempt and one attempt per seed offset.
// Results then leave in node order, each after a membership read, or as a
// single failure transfer; a rsp stall holds the output register and the
// sequencer. Configuration writes on the csr channel are taken at any cycle
// and must only be issued while the block is idle.
// A synchronous reset clears control state and restores head_count 4 and
// pass_limit 255; no memory clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kmedoid_cluster_heads_core #(
   parameter int MAX_NODES = 64,
   parameter int MAX_HEADS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  kch_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output kch_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_data
);

   localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW  = $clog2(MAX_NODES + 1);
   localparam int HW  = (MAX_HEADS > 1) ? $clog2(MAX_HEADS) : 1;
   localparam int XW  = CW + 5;
   localparam int CRW = kch_pkg::COORD_W;

   kch_pkg::state_type state_ff, state_in;

   logic [CW-1:0]  node_cnt_ff, node_cnt_in;
   logic [NW-1:0]  i_ff, i_in, j_ff, j_in, best_ff, best_in;
   logic [HW-1:0]  c_ff, c_in, bc_ff, bc_in, head_sel;
   logic [3:0]     k_ff, k_in, head_count_ff, k_sat;
   logic [CW-1:0]  retry_ff, retry_in;
   logic [7:0]     pass_ff, pass_in, pass_limit_ff;
   logic           moved_ff, moved_in, found_ff, found_in;
   logic [CRW-1:0] bx_ff, bx_in, by_ff, by_in, xi_ff, xi_in, yi_ff, yi_in;
   logic [kch_pkg::DIST_W-1:0] bd_ff, bd_in;
   logic [kch_pkg::COST_W-1:0] cost_ff, cost_in, best_cost_ff, best_cost_in;
   logic [NW-1:0]  head_node_ff [MAX_HEADS];
   logic [NW-1:0]  head_node_in [MAX_HEADS];
   logic [CRW-1:0] head_x_ff [MAX_HEADS];
   logic [CRW-1:0] head_x_in [MAX_HEADS];
   logic [CRW-1:0] head_y_ff [MAX_HEADS];
   logic [CRW-1:0] head_y_in [MAX_HEADS];
   logic           rsp_valid_ff, rsp_valid_in;
   kch_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [2*CRW-1:0] coord_mem [MAX_NODES];
   logic [2:0]       member_mem [MAX_NODES];
   logic [2*CRW-1:0] coord_rd_ff;
   logic [2:0]       member_rd_ff;
   logic [NW-1:0]    rd_addr;
   logic             coord_we, member_we;

   logic             dist_start, dist_done, sqrt_start, sqrt_done;
   kch_pkg::pair_type pair;
   logic [kch_pkg::DIST_W-1:0] sq_dist;
   logic [kch_pkg::ROOT_W-1:0] root;

   logic           req_accept, slot_free, last_i, last_j, last_c, dup;
   logic [NW-1:0]  hn_sel;
   logic [CRW-1:0] hx_sel, hy_sel;

   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff != kch_pkg::S_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign k_sat  = (head_count_ff > 4'(MAX_HEADS)) ? 4'(MAX_HEADS) : head_count_ff;
   assign last_i = (CW'(i_ff) + CW'(1)) == node_cnt_ff;
   assign last_j = (CW'(j_ff) + CW'(1)) == node_cnt_ff;
   assign last_c = (4'(c_ff) + 4'd1) == k_ff;

   assign head_sel = (state_ff == kch_pkg::S_OUT) ? HW'(member_rd_ff) : c_ff;
   assign hn_sel   = head_node_ff[head_sel];
   assign hx_sel   = head_x_ff[head_sel];
   assign hy_sel   = head_y_ff[head_sel];

   always_comb begin
      dup = 1'b0;
      for (int a = 0; a < MAX_HEADS; a++) begin
         for (int b = 0; b < MAX_HEADS; b++) begin
            if (a < b && 4'(b) < k_ff && head_node_ff[a] == head_node_ff[b]) begin
               dup = 1'b1;
            end
         end
      end
   end

   always_comb begin
      if (state_ff == kch_pkg::S_UPD_CHK_J) begin
         pair.a_x = xi_ff;
         pair.a_y = yi_ff;
      end else begin
         pair.a_x = coord_rd_ff[2*CRW-1:CRW];
         pair.a_y = coord_rd_ff[CRW-1:0];
      end
      if (state_ff == kch_pkg::S_UPD_CHK_J) begin
         pair.b_x = coord_rd_ff[2*CRW-1:CRW];
         pair.b_y = coord_rd_ff[CRW-1:0];
      end else begin
         pair.b_x = hx_sel;
         pair.b_y = hy_sel;
      end
   end

   always_comb begin
      state_in     = state_ff;
      node_cnt_in  = node_cnt_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      c_in         = c_ff;
      k_in         = k_ff;
      retry_in     = retry_ff;
      pass_in      = pass_ff;
      moved_in     = moved_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      xi_in        = xi_ff;
      yi_in        = yi_ff;
      bd_in        = bd_ff;
      bc_in        = bc_ff;
      cost_in      = cost_ff;
      best_cost_in = best_cost_ff;
      head_node_in = head_node_ff;
      head_x_in    = head_x_ff;
      head_y_in    = head_y_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = i_ff;
      coord_we     = 1'b0;
      member_we    = 1'b0;
      dist_start   = 1'b0;
      sqrt_start   = 1'b0;

      case (state_ff)
         kch_pkg::S_LOAD: begin
            if (req_accept) begin
               if (node_cnt_ff < CW'(MAX_NODES)) begin
                  coord_we    = 1'b1;
                  node_cnt_in = node_cnt_ff + CW'(1);
               end
               if (req_data.last_node) begin
                  retry_in = '0;
                  state_in = kch_pkg::S_START;
               end
            end
         end
         kch_pkg::S_START: begin
            k_in = k_sat;
            c_in = '0;
            if (k_sat == 4'd0 ||
                XW'(retry_ff) + XW'(k_sat) > XW'(node_cnt_ff)) begin
               state_in = kch_pkg::S_FAIL;
            end else begin
               state_in = kch_pkg::S_SEED_RD;
            end
         end
         kch_pkg::S_SEED_RD: begin
            rd_addr  = NW'(retry_ff + CW'(c_ff));
            state_in = kch_pkg::S_SEED_WR;
         end
         kch_pkg::S_SEED_WR: begin
            head_node_in[c_ff] = NW'(retry_ff + CW'(c_ff));
            head_x_in[c_ff]    = coord_rd_ff[2*CRW-1:CRW];
            head_y_in[c_ff]    = coord_rd_ff[CRW-1:0];
            if (last_c) begin
               pass_in  = '0;
               moved_in = 1'b0;
               i_in     = '0;
               c_in     = '0;
               state_in = kch_pkg::S_ASG_RD;
            end else begin
               c_in     = c_ff + HW'(1);
               state_in = kch_pkg::S_SEED_RD;
            end
         end
         kch_pkg::S_ASG_RD: begin
            c_in     = '0;
            state_in = kch_pkg::S_ASG_DIST;
         end
         kch_pkg::S_ASG_DIST: begin
            dist_start = 1'b1;
            state_in   = kch_pkg::S_ASG_WAIT;
         end
         kch_pkg::S_ASG_WAIT: begin
            if (dist_done) begin
               if (c_ff == '0 || sq_dist < bd_ff) begin
                  bd_in = sq_dist;
                  bc_in = c_ff;
               end
               if (last_c) begin
                  state_in = kch_pkg::S_ASG_WR;
               end else begin
                  c_in     = c_ff + HW'(1);
                  state_in = kch_pkg::S_ASG_DIST;
               end
            end
         end
         kch_pkg::S_ASG_WR: begin
            member_we = 1'b1;
            if (last_i) begin
               i_in     = '0;
               c_in     = '0;
               state_in = kch_pkg::S_UPD_INIT;
            end else begin
               i_in     = i_ff + NW'(1);
               state_in = kch_pkg::S_ASG_RD;
            end
         end
         kch_pkg::S_UPD_INIT: begin
            found_in     = 1'b0;
            best_in      = hn_sel;
            bx_in        = hx_sel;
            by_in        = hy_sel;
            best_cost_in = '0;
            i_in         = '0;
            state_in     = kch_pkg::S_UPD_RD_I;
         end
         kch_pkg::S_UPD_RD_I: begin
            state_in = kch_pkg::S_UPD_CHK_I;
         end
         kch_pkg::S_UPD_CHK_I: begin
            if (member_rd_ff != 3'(c_ff)) begin
               state_in = kch_pkg::S_UPD_NEXT_I;
            end else begin
               xi_in    = coord_rd_ff[2*CRW-1:CRW];
               yi_in    = coord_rd_ff[CRW-1:0];
               cost_in  = '0;
               j_in     = '0;
               state_in = kch_pkg::S_UPD_RD_J;
            end
         end
         kch_pkg::S_UPD_RD_J: begin
            rd_addr  = j_ff;
            state_in = kch_pkg::S_UPD_CHK_J;
         end
         kch_pkg::S_UPD_CHK_J: begin
            rd_addr = j_ff;
            if (j_ff != i_ff && member_rd_ff == 3'(c_ff)) begin
               dist_start = 1'b1;
               state_in   = kch_pkg::S_UPD_WAIT;
            end else begin
               state_in = kch_pkg::S_UPD_NEXT_J;
            end
         end
         kch_pkg::S_UPD_WAIT: begin
            if (dist_done) begin
               sqrt_start = 1'b1;
               state_in   = kch_pkg::S_UPD_SQRT;
            end
         end
         kch_pkg::S_UPD_SQRT: begin
            if (sqrt_done) begin
               cost_in  = cost_ff + kch_pkg::COST_W'(root);
               state_in = kch_pkg::S_UPD_NEXT_J;
            end
         end
         kch_pkg::S_UPD_NEXT_J: begin
            if (last_j) begin
               if (!found_ff || cost_ff < best_cost_ff) begin
                  found_in     = 1'b1;
                  best_cost_in = cost_ff;
                  best_in      = i_ff;
                  bx_in        = xi_ff;
                  by_in        = yi_ff;
               end
               state_in = kch_pkg::S_UPD_NEXT_I;
            end else begin
               j_in     = j_ff + NW'(1);
               state_in = kch_pkg::S_UPD_RD_J;
            end
         end
         kch_pkg::S_UPD_NEXT_I: begin
            if (last_i) begin
               if (bx_ff != hx_sel || by_ff != hy_sel) begin
                  moved_in = 1'b1;
               end
               head_node_in[c_ff] = best_ff;
               head_x_in[c_ff]    = bx_ff;
               head_y_in[c_ff]    = by_ff;
               if (last_c) begin
                  state_in = kch_pkg::S_PASS_END;
               end else begin
                  c_in     = c_ff + HW'(1);
                  state_in = kch_pkg::S_UPD_INIT;
               end
            end else begin
               i_in     = i_ff + NW'(1);
               state_in = kch_pkg::S_UPD_RD_I;
            end
         end
         kch_pkg::S_PASS_END: begin
            pass_in = pass_ff + 8'd1;
            if (!moved_ff) begin
               state_in = kch_pkg::S_DUP;
            end else if ({1'b0, pass_ff} + 9'd1 >= {1'b0, pass_limit_ff}) begin
               state_in = kch_pkg::S_FAIL;
            end else begin
               moved_in = 1'b0;
               i_in     = '0;
               state_in = kch_pkg::S_ASG_RD;
            end
         end
         kch_pkg::S_DUP: begin
            i_in = '0;
            if (dup) begin
               retry_in = retry_ff + CW'(1);
               state_in = kch_pkg::S_START;
            end else begin
               state_in = kch_pkg::S_OUT_RD;
            end
         end
         kch_pkg::S_OUT_RD: begin
            state_in = kch_pkg::S_OUT;
         end
         kch_pkg::S_OUT: begin
            if (slot_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.node_index    = 6'(i_ff);
               rsp_data_in.cluster_index = member_rd_ff;
               rsp_data_in.head_node     = 6'(hn_sel);
               rsp_data_in.is_head       = (hn_sel == i_ff);
               rsp_data_in.failed        = 1'b0;
               rsp_data_in.last          = last_i;
               if (last_i) begin
                  node_cnt_in = '0;
                  state_in    = kch_pkg::S_LOAD;
               end else begin
                  i_in     = i_ff + NW'(1);
                  state_in = kch_pkg::S_OUT_RD;
               end
            end
         end
         kch_pkg::S_FAIL: begin
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in        = '0;
               rsp_data_in.failed = 1'b1;
               rsp_data_in.last   = 1'b1;
               node_cnt_in        = '0;
               state_in           = kch_pkg::S_LOAD;
            end
         end
         default: begin
            state_in = kch_pkg::S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kch_pkg::S_LOAD;
         node_cnt_ff   <= '0;
         retry_ff      <= '0;
         pass_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         head_count_ff <= kch_pkg::HEAD_COUNT_RESET;
         pass_limit_ff <= kch_pkg::PASS_LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         node_cnt_ff  <= node_cnt_in;
         retry_ff     <= retry_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == kch_pkg::CSR_HEAD_COUNT) begin
               head_count_ff <= csr_data[3:0];
            end else if (csr_index == kch_pkg::CSR_PASS_LIMIT) begin
               pass_limit_ff <= csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      c_ff         <= c_in;
      k_ff         <= k_in;
      moved_ff     <= moved_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      bx_ff        <= bx_in;
      by_ff        <= by_in;
      xi_ff        <= xi_in;
      yi_ff        <= yi_in;
      bd_ff        <= bd_in;
      bc_ff        <= bc_in;
      cost_ff      <= cost_in;
      best_cost_ff <= best_cost_in;
      head_node_ff <= head_node_in;
      head_x_ff    <= head_x_in;
      head_y_ff    <= head_y_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (coord_we) begin
         coord_mem[NW'(node_cnt_ff)] <= {req_data.x_coord, req_data.y_coord};
      end
      if (member_we) begin
         member_mem[i_ff] <= 3'(bc_ff);
      end
      coord_rd_ff  <= coord_mem[rd_addr];
      member_rd_ff <= member_mem[rd_addr];
   end

   kch_dist u_dist (
      .clock   (clock),
      .reset   (reset),
      .start   (dist_start),
      .pair    (pair),
      .done    (dist_done),
      .sq_dist (sq_dist)
   );

   kch_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (sq_dist),
      .done  (sqrt_done),
      .root  (root)
   );

   `KCH_ASSERT(a_rsp_source,
      $rose(rsp_valid) |-> $past(state_ff == kch_pkg::S_OUT || state_ff == kch_pkg::S_FAIL),
      "result appeared outside the output states")
   `KCH_ASSERT(a_node_cnt_max, node_cnt_ff <= CW'(MAX_NODES), "node count beyond store depth")
   `KCH_ASSERT_IMPL(a_member_range, state_ff == kch_pkg::S_OUT, 4'(member_rd_ff) < k_ff,
      "member cluster beyond head count")
   `KCH_ASSERT_IMPL(a_asg_index, state_ff == kch_pkg::S_ASG_WR, CW'(i_ff) < node_cnt_ff,
      "membership write beyond node count")

endmodule

### test/kmedoid_cluster_heads_core_test.sv
// Testbench for the k-medoids cluster head selection block: predictions against outputs.
`timescale 1ns / 1ps

module kmedoid_cluster_heads_core_test;

   localparam int NODE_CAP = 64;
   localparam int HEAD_CAP = 8;
   localparam int IDLE_LIMIT = 50000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   kch_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   kch_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_data = '0;

   kmedoid_cluster_heads_core DUT (.*);

   kch_pkg::req_type pending_nodes[$];
   kch_pkg::rsp_type expected_heads[$];

   logic [3:0] head_count_reg = kch_pkg::HEAD_COUNT_RESET;
   logic [7:0] pass_limit_reg = kch_pkg::PASS_LIMIT_RESET;
   logic signed [15:0] node_x[NODE_CAP];
   logic signed [15:0] node_y[NODE_CAP];
   logic [2:0] node_cluster[NODE_CAP];
   logic [5:0] head_of[HEAD_CAP];
   int loaded_nodes = 0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_cycles = 0;
   int errors = 0;
   int idle_cycles = 0;
   int run_count = 0;
   int fail_count = 0;
   int result_count = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint dist_sq(int a, int b);
      longint dx, dy;
      dx = longint'(node_x[a]) - longint'(node_x[b]);
      dy = longint'(node_y[a]) - longint'(node_y[b]);
      return dx * dx + dy * dy;
   endfunction

   function automatic longint floor_root(longint v);
      longint r, bit_v;
      r = 0;
      bit_v = 64'sd1 <<< 62;
      while (bit_v > v) bit_v = bit_v >>> 2;
      while (bit_v != 0) begin
         if (v >= r + bit_v) begin
            v = v - (r + bit_v);
            r = (r >>> 1) + bit_v;
         end else begin
            r = r >>> 1;
         end
         bit_v = bit_v >>> 2;
      end
      return r;
   endfunction

   function automatic bit select_heads(int n, int k);
      int offset, passes, best, bc;
      longint bd, d, cost, best_cost;
      bit moved, dup, found;
      offset = 0;
      forever begin
         if (offset + k > n) return 1'b0;
         for (int c = 0; c < k; c++) head_of[c] = 6'(offset + c);
         passes = 0;
         forever begin
            moved = 1'b0;
            for (int i = 0; i < n; i++) begin
               bd = 0;
               bc = 0;
               for (int c = 0; c < k; c++) begin
                  d = dist_sq(i, head_of[c]);
                  if (c == 0 || d < bd) begin
                     bd = d;
                     bc = c;
                  end
               end
               node_cluster[i] = 3'(bc);
            end
            for (int c = 0; c < k; c++) begin
               found = 1'b0;
               best = head_of[c];
               best_cost = 0;
               for (int i = 0; i < n; i++) begin
                  if (node_cluster[i] == c) begin
                     cost = 0;
                     for (int j = 0; j < n; j++)
                        if (j != i && node_cluster[j] == c) cost += floor_root(dist_sq(i, j));
                     if (!found || cost < best_cost) begin
                        found = 1'b1;
                        best_cost = cost;
                        best = i;
                     end
                  end
               end
               if (node_x[best] != node_x[head_of[c]] || node_y[best] != node_y[head_of[c]])
                  moved = 1'b1;
               head_of[c] = 6'(best);
            end
            passes++;
            if (!moved) break;
            if (passes >= pass_limit_reg) return 1'b0;
         end
         dup = 1'b0;
         for (int i = 0; i < k; i++)
            for (int j = i + 1; j < k; j++)
               if (head_of[i] == head_of[j]) dup = 1'b1;
         if (!dup) return 1'b1;
         offset++;
      end
   endfunction

   task automatic predict_node(kch_pkg::req_type item);
      int n, k;
      bit ok;
      kch_pkg::rsp_type r;
      if (loaded_nodes < NODE_CAP) begin
         node_x[loaded_nodes] = item.x_coord;
         node_y[loaded_nodes] = item.y_coord;
         loaded_nodes++;
      end
      if (!item.last_node) return;
      n = loaded_nodes;
      k = (head_count_reg > HEAD_CAP) ? HEAD_CAP : head_count_reg;
      ok = (k != 0) && select_heads(n, k);
      loaded_nodes = 0;
      run_count++;
      if (!ok) begin
         r = '0;
         r.failed = 1'b1;
         r.last = 1'b1;
         expected_heads = {expected_heads, r};
         fail_count++;
         return;
      end
      for (int i = 0; i < n; i++) begin
         r = '0;
         r.node_index = 6'(i);
         r.cluster_index = node_cluster[i];
         r.head_node = head_of[node_cluster[i]];
         r.is_head = (head_of[node_cluster[i]] == i);
         r.last = (i + 1 == n);
         expected_heads = {expected_heads, r};
      end
   endtask

   // Driver: offers queued nodes and predicts each one as it is accepted.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) predict_node(req_data);
         if (!req_valid || !req_stall) begin
            if (pending_nodes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_nodes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks every result transfer against the oldest prediction.
   always @(posedge clock) begin
      kch_pkg::rsp_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (expected_heads.size() == 0) begin
               $error("unexpected result %p", rsp_data);
               errors++;
            end else begin
               e = expected_heads.pop_front();
               if (rsp_data.node_index !== e.node_index) begin
                  $error("node_index expected %0d actual %0d", e.node_index, rsp_data.node_index);
                  errors++;
               end
               if (rsp_data.cluster_index !== e.cluster_index) begin
                  $error("cluster_index expected %0d actual %0d", e.cluster_index,
                         rsp_data.cluster_index);
                  errors++;
               end
               if (rsp_data.head_node !== e.head_node) begin
                  $error("head_node expected %0d actual %0d", e.head_node, rsp_data.head_node);
                  errors++;
               end
               if (rsp_data.is_head !== e.is_head) begin
                  $error("is_head expected %0d actual %0d", e.is_head, rsp_data.is_head);
                  errors++;
               end
               if (rsp_data.failed !== e.failed) begin
                  $error("failed expected %0d actual %0d", e.failed, rsp_data.failed);
                  errors++;
               end
               if (rsp_data.last !== e.last) begin
                  $error("last expected %0d actual %0d", e.last, rsp_data.last);
                  errors++;
               end
            end
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == kch_pkg::CSR_HEAD_COUNT) head_count_reg = value[3:0];
      else pass_limit_reg = value;
   endtask

   task automatic drain();
      while (pending_nodes.size() > 0 || req_valid || expected_heads.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic add_node(int x, int y, bit last_flag);
      kch_pkg::req_type item;
      item.x_coord = 16'(x);
      item.y_coord = 16'(y);
      item.last_node = last_flag;
      pending_nodes = {pending_nodes, item};
   endtask

   // Mostly small sets drawn from four blobs; about one node in ten gets random coordinates.
   task automatic add_random_set(int n);
      int cx[4], cy[4], b, spread;
      spread = 1 << $urandom_range(3, 11);
      for (int c = 0; c < 4; c++) begin
         cx[c] = $urandom_range(0, 65535) - 32768;
         cy[c] = $urandom_range(0, 65535) - 32768;
      end
      for (int i = 0; i < n; i++) begin
         b = $urandom_range(3);
         if ($urandom_range(9) == 0)
            add_node($urandom_range(0, 65535), $urandom_range(0, 65535), i == n - 1);
         else
            add_node(cx[b] + $urandom_range(0, spread), cy[b] + $urandom_range(0, spread),
                     i == n - 1);
      end
   endtask

   initial begin
      int sent;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settings, extreme coordinates, too few nodes (two, then one).
      add_node(-32768, -32768, 0);
      add_node(32767, 32767, 0);
      add_node(-32768, 32767, 0);
      add_node(32767, -32768, 0);
      add_node(0, 0, 1);
      add_node(5, 5, 0);
      add_node(6, 6, 1);
      add_node(0, 0, 1);
      drain();
      // Two heads, pass limit zero: identical nodes, then two separated pairs.
      write_csr(kch_pkg::CSR_HEAD_COUNT, 8'd2);
      write_csr(kch_pkg::CSR_PASS_LIMIT, 8'd0);
      add_node(7, 7, 0);
      add_node(7, 7, 0);
      add_node(7, 7, 1);
      add_node(1, 1, 0);
      add_node(2, 1, 0);
      add_node(100, 100, 0);
      add_node(101, 100, 1);
      drain();
      write_csr(kch_pkg::CSR_HEAD_COUNT, 8'd0);
      add_node(1, 2, 1);
      drain();
      write_csr(kch_pkg::CSR_HEAD_COUNT, 8'd15);
      write_csr(kch_pkg::CSR_PASS_LIMIT, 8'd255);
      add_random_set(10);
      drain();
      write_csr(kch_pkg::CSR_HEAD_COUNT, 8'd1);
      add_node(3, 4, 1);
      drain();
      // Store full: 66 nodes, the last two dropped.
      write_csr(kch_pkg::CSR_HEAD_COUNT, 8'd3);
      write_csr(kch_pkg::CSR_PASS_LIMIT, 8'd16);
      for (int i = 0; i < 66; i++) add_node($urandom_range(0, 65535), $urandom_range(0, 65535),
                                            i == 65);
      drain();

      sent = 0;
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 34 : 70) : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 34 : 70) : 0;
         write_csr(kch_pkg::CSR_HEAD_COUNT, 8'($urandom_range(1, 8)));
         write_csr(kch_pkg::CSR_PASS_LIMIT,
                   ($urandom_range(3) == 0) ? 8'($urandom_range(1, 3)) : 8'd255);
         if (phase == 0) hold_off_cycles = 20000;
         for (int s = 0; s < 6; s++) begin
            int n;
            n = ($urandom_range(4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 14);
            add_random_set(n);
            sent += n;
         end
         drain();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
      $display("Ran %0d clustering runs with %0d random nodes, %0d results, %0d failures.",
               run_count, sent, result_count, fail_count);
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule

### filelist.f
+incdir+sv
sv/kch_pkg.sv
sv/kch_dist.sv
sv/kch_isqrt.sv
sv/kmedoid_cluster_heads_core.sv
test/kmedoid_cluster_heads_core_test.sv
